@@ rtl/core/deq_pkg.sv @@
package deq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W = 3;
  localparam int FIELD_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_DUMP
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                at_front;
    logic [FIELD_W-1:0]  value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_RD,
    BK_DUMP_RQ,
    BK_DUMP_RD
  } back_state_t;

endpackage

@@ rtl/core/deq_ram.sv @@
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/deq_front.sv @@
module deq_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [deq_pkg::OP_W-1:0]    op,
  input  logic [deq_pkg::FIELD_W-1:0] value,
  output logic                        push_valid,
  input  logic                        push_ready,
  output deq_pkg::cmd_t               push_cmd
);

  logic known;

  always_comb begin
    known = 1'b1;
    push_cmd.value = value;
    push_cmd.kind = deq_pkg::KIND_PUSH;
    push_cmd.at_front = 1'b1;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        push_cmd.kind = deq_pkg::KIND_PUSH;
        push_cmd.at_front = 1'b1;
      end
      deq_pkg::OP_PUSH_BACK: begin
        push_cmd.kind = deq_pkg::KIND_PUSH;
        push_cmd.at_front = 1'b0;
      end
      deq_pkg::OP_POP_FRONT: begin
        push_cmd.kind = deq_pkg::KIND_POP;
        push_cmd.at_front = 1'b1;
      end
      deq_pkg::OP_POP_BACK: begin
        push_cmd.kind = deq_pkg::KIND_POP;
        push_cmd.at_front = 1'b0;
      end
      deq_pkg::OP_DUMP_FWD: begin
        push_cmd.kind = deq_pkg::KIND_DUMP;
        push_cmd.at_front = 1'b1;
      end
      deq_pkg::OP_DUMP_BWD: begin
        push_cmd.kind = deq_pkg::KIND_DUMP;
        push_cmd.at_front = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown operations are taken and dropped without reaching the back end.
  assign in_ready = push_ready;
  assign push_valid = in_valid && known;

endmodule

@@ rtl/core/deq_cmdq.sv @@
module deq_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  deq_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output deq_pkg::cmd_t pop_cmd
);

  deq_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid = fill != 2'd0;
  assign pop_cmd = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/core/deq_back.sv @@
module deq_back #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  deq_pkg::cmd_t                cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [deq_pkg::FIELD_W-1:0]  data,
  output logic [deq_pkg::STATUS_W-1:0] status,
  output logic                         last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   RING_SIZE = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
  localparam logic [PTR_W-1:0] PTR_BACK = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= RING_SIZE) begin
      s = s - RING_SIZE;
    end
    return s[PTR_W-1:0];
  endfunction

  deq_pkg::back_state_t state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] idx, idx_next;
  logic             backward, backward_next;

  logic                         out_free;
  logic                         out_load;
  logic [deq_pkg::FIELD_W-1:0]  load_data;
  logic [deq_pkg::STATUS_W-1:0] load_status;
  logic                         load_last;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  is_empty;
  logic                  is_full;
  logic [CNT_W-1:0]      cnt_m1;
  logic [PTR_W-1:0]      last_off;
  logic [PTR_W-1:0]      dump_off;

  logic signed [deq_pkg::FIELD_W-1:0] in_s;
  logic signed [63:0]                 in_ext;
  logic signed [DATA_WIDTH-1:0]       rd_s;
  logic signed [63:0]                 rd_ext;

  deq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign is_empty = count == '0;
  assign is_full = count == CNT_FULL;
  assign cnt_m1 = count - CNT_ONE;
  assign last_off = cnt_m1[PTR_W-1:0];
  assign dump_off = backward ? (last_off - idx) : idx;

  assign in_s = cmd.value;
  assign in_ext = 64'(in_s);
  assign ram_wdata = in_ext[DATA_WIDTH-1:0];
  assign rd_s = ram_rdata;
  assign rd_ext = 64'(rd_s);

  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          if (cmd.kind == deq_pkg::KIND_POP && !is_empty) begin
            state_next = deq_pkg::BK_POP_RD;
          end else if (cmd.kind == deq_pkg::KIND_DUMP && !is_empty) begin
            state_next = deq_pkg::BK_DUMP_RQ;
          end
        end
      end
      deq_pkg::BK_POP_RD: begin
        state_next = deq_pkg::BK_IDLE;
      end
      deq_pkg::BK_DUMP_RQ: begin
        if (out_free) begin
          state_next = deq_pkg::BK_DUMP_RD;
        end
      end
      deq_pkg::BK_DUMP_RD: begin
        state_next = (idx == last_off) ? deq_pkg::BK_IDLE : deq_pkg::BK_DUMP_RQ;
      end
      default: begin
        state_next = deq_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = head;
    ram_raddr = head;
    head_next = head;
    count_next = count;
    idx_next = idx;
    backward_next = backward;
    out_load = 1'b0;
    load_data = '0;
    load_status = deq_pkg::ST_OK;
    load_last = 1'b1;
    case (state)
      deq_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            deq_pkg::KIND_PUSH: begin
              out_load = 1'b1;
              if (is_full) begin
                load_status = deq_pkg::ST_OVERFLOW;
              end else begin
                ram_we = 1'b1;
                count_next = count + CNT_ONE;
                if (cmd.at_front) begin
                  ram_waddr = ring_add(head, PTR_BACK);
                  head_next = ring_add(head, PTR_BACK);
                end else begin
                  ram_waddr = ring_add(head, count[PTR_W-1:0]);
                end
              end
            end
            deq_pkg::KIND_POP: begin
              if (is_empty) begin
                out_load = 1'b1;
                load_status = deq_pkg::ST_UNDERFLOW;
              end else begin
                count_next = cnt_m1;
                if (cmd.at_front) begin
                  ram_raddr = head;
                  head_next = ring_add(head, PTR_ONE);
                end else begin
                  ram_raddr = ring_add(head, last_off);
                end
              end
            end
            deq_pkg::KIND_DUMP: begin
              if (is_empty) begin
                out_load = 1'b1;
                load_status = deq_pkg::ST_EMPTY;
              end else begin
                idx_next = '0;
                backward_next = !cmd.at_front;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      deq_pkg::BK_POP_RD: begin
        out_load = 1'b1;
        load_data = rd_ext[deq_pkg::FIELD_W-1:0];
      end
      deq_pkg::BK_DUMP_RQ: begin
        ram_raddr = ring_add(head, dump_off);
      end
      deq_pkg::BK_DUMP_RD: begin
        out_load = 1'b1;
        load_data = rd_ext[deq_pkg::FIELD_W-1:0];
        load_last = idx == last_off;
        idx_next = idx + PTR_ONE;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::BK_IDLE;
      head <= '0;
      count <= '0;
      idx <= '0;
      backward <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
      idx <= idx_next;
      backward <= backward_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data <= load_data;
      status <= load_status;
      last <= load_last;
    end
  end

endmodule

@@ rtl/core/bounded_deque_with_dump.sv @@
// Path: with the back end idle, a push result or any error result passes the command queue
// slot and the output register; a pop result also passes the registered RAM read, and each
// dump result passes the BK_DUMP_RQ and BK_DUMP_RD states around the registered RAM read.
// Throughput: one push or error per cycle while the back end is idle and out_ready keeps the
// output free; a pop or a dump holds the back end until its read-then-emit sequence is done.
// Reset: synchronous; empties the queue and clears all control state, RAM is not cleared.
module bounded_deque_with_dump #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::OP_W-1:0]            op,
  input  logic signed [deq_pkg::FIELD_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [deq_pkg::FIELD_W-1:0]  data,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic                                last
);

  logic          fq_valid;
  logic          fq_ready;
  deq_pkg::cmd_t fq_cmd;
  logic          qb_valid;
  logic          qb_ready;
  deq_pkg::cmd_t qb_cmd;
  logic [deq_pkg::FIELD_W-1:0] data_u;

  deq_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_cmd  (fq_cmd)
  );

  deq_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_cmd  (fq_cmd),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_cmd   (qb_cmd)
  );

  deq_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(qb_valid),
    .cmd_ready(qb_ready),
    .cmd      (qb_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data     (data_u),
    .status   (status),
    .last     (last)
  );

  assign data = data_u;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDLE_PCT = 26;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS = 100;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic signed [FIELD_W-1:0] data;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            op = OP_PUSH_BACK;
  logic signed [FIELD_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [FIELD_W-1:0]  data;
  logic [STATUS_W-1:0]        status;
  logic                       last;

  logic signed [FIELD_W-1:0]  ring_mem [DEPTH];
  int                         ring_head = 0;
  int                         ring_count = 0;
  result_t                    pending_results [$];
  int                         error_count = 0;
  int                         idle_cycles = 0;
  bit                         steady = 1'b0;

  bounded_deque_with_dump dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data(data),
    .status(status),
    .last(last)
  );

  always #2 clk = ~clk;

  function automatic void expect_result(logic signed [FIELD_W-1:0] d,
                                        logic [STATUS_W-1:0] s, logic l);
    result_t r;
    r.data = d;
    r.status = s;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void deque_apply(logic [OP_W-1:0] code,
                                      logic signed [FIELD_W-1:0] v);
    int idx;
    case (code)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          expect_result('0, ST_OVERFLOW, 1'b1);
        end else begin
          if (code == OP_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_mem[ring_head] = v;
          end else begin
            ring_mem[(ring_head + ring_count) % DEPTH] = v;
          end
          ring_count++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (ring_count == 0) begin
          expect_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          if (code == OP_POP_FRONT) begin
            expect_result(ring_mem[ring_head], ST_OK, 1'b1);
            ring_head = (ring_head + 1) % DEPTH;
          end else begin
            expect_result(ring_mem[(ring_head + ring_count - 1) % DEPTH], ST_OK, 1'b1);
          end
          ring_count--;
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        if (ring_count == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            idx = (code == OP_DUMP_FWD) ? i : ring_count - 1 - i;
            expect_result(ring_mem[(ring_head + idx) % DEPTH], ST_OK,
                          i == ring_count - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    end
  endtask

  // Prediction and checking share one process so that their order is fixed.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        deque_apply(op, value);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat, data", data, 0);
        end else begin
          want = pending_results.pop_front();
          if (data !== want.data) report_mismatch("data", data, want.data);
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(logic [OP_W-1:0] code, logic signed [FIELD_W-1:0] val);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_POP_BACK, $urandom);
    send_beat(OP_DUMP_FWD, $urandom);
    send_beat(OP_DUMP_BWD, $urandom);
  endtask

  task automatic test_extremes();
    send_beat(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_beat(OP_PUSH_FRONT, 32'sh8000_0000);
    send_beat(OP_PUSH_BACK, '0);
    send_beat(OP_PUSH_FRONT, -1);
    send_beat(OP_DUMP_FWD, '0);
    send_beat(OP_DUMP_BWD, -1);
    send_beat(OP_POP_FRONT, '0);
    send_beat(OP_POP_BACK, '0);
    send_beat(OP_RSVD6, 32'sh5555_aaaa);
    send_beat(OP_RSVD7, 32'shaaaa_5555);
    send_beat(OP_POP_FRONT, '0);
    send_beat(OP_POP_BACK, '0);
    send_beat(OP_POP_FRONT, '0);
  endtask

  // Fill to the brim with both idling sources off, try overflow and dumps, then drain again.
  task automatic test_fill_and_overflow();
    steady = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      send_beat($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    end
    send_beat(OP_PUSH_FRONT, $urandom);
    send_beat(OP_PUSH_BACK, $urandom);
    send_beat(OP_DUMP_FWD, $urandom);
    send_beat(OP_DUMP_BWD, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_beat($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
    end
    steady = 1'b0;
  endtask

  // The push share drifts between phases so the queue swings between empty and full.
  task automatic test_random_mix(int count);
    int done;
    int push_pct;
    int roll;
    done = 0;
    push_pct = 50;
    while (done < count) begin
      if (done % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_beat($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7, $urandom);
      end else begin
        if (roll < 8) begin
          send_beat($urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BWD, $urandom);
        end else if ($urandom_range(0, 99) < push_pct) begin
          send_beat($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        end else begin
          send_beat($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_extremes();
    test_fill_and_overflow();
    test_random_mix(300);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ bounded_deque_with_dump.f @@
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_front.sv
rtl/core/deq_cmdq.sv
rtl/core/deq_back.sv
rtl/core/bounded_deque_with_dump.sv
tb/sv/tb_top.sv
